>>> rtl/core/rbma_pkg.sv
// Shared types, codes, widths and arithmetic helpers of the rectangle blit core.
package rbma_pkg;

  localparam int MAX_DIM_DEF = 64;

  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W = 6;
  localparam int RGBA_W  = 32;
  localparam int RECT_W  = 8;
  localparam int SIZE_W  = 7;
  localparam int CNT_W   = 13;
  localparam int POS_W   = 10;
  localparam int LIN_W   = 14;

  localparam logic [1:0] REQ_WR_SRC = 2'd0;
  localparam logic [1:0] REQ_WR_DST = 2'd1;
  localparam logic [1:0] REQ_BLIT   = 2'd2;
  localparam logic [1:0] REQ_RD_DST = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

  localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 7'd64;
  localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 7'd64;
  localparam logic [CFG_W-1:0] DST_WIDTH_RST  = 7'd16;
  localparam logic [CFG_W-1:0] DST_HEIGHT_RST = 7'd32;

  localparam logic [7:0] ALPHA_MIN    = 8'd3;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [COORD_W-1:0]       pixel_x;
    logic [COORD_W-1:0]       pixel_y;
    logic [RGBA_W-1:0]        pixel_rgba;
    logic signed [RECT_W-1:0] rect_src_x;
    logic signed [RECT_W-1:0] rect_src_y;
    logic [SIZE_W-1:0]        rect_width;
    logic [SIZE_W-1:0]        rect_height;
    logic signed [RECT_W-1:0] rect_dst_x;
    logic signed [RECT_W-1:0] rect_dst_y;
    logic                     mirror_flag;
    logic                     blend_flag;
  } req_t;

  typedef struct packed {
    logic [RGBA_W-1:0] read_rgba;
    logic [CNT_W-1:0]  pixels_written;
    logic              in_range;
  } rsp_t;

  // Exact floor(v / 255) for every v below 255 * 256.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + {9'd0, v[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

>>> rtl/core/rbma_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rbma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/rbma_blend.sv
// Alpha blend stage: registers weighted channel sums, then scales them by 1/255.
module rbma_blend #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [AW-1:0] in_addr,
  input  logic [31:0]   src,
  input  logic [31:0]   dst,
  output logic          out_valid,
  output logic [AW-1:0] out_addr,
  output logic [31:0]   out_data
);

  logic [7:0]  alpha;
  logic [7:0]  alpha_inv;
  logic [15:0] sum_next [3];
  logic [15:0] sum [3];

  assign alpha     = src[31:24];
  assign alpha_inv = rbma_pkg::ALPHA_OPAQUE - alpha;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_next[c] = ({8'd0, src[c*8 +: 8]} * {8'd0, alpha})
                  + ({8'd0, dst[c*8 +: 8]} * {8'd0, alpha_inv});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid && (alpha >= rbma_pkg::ALPHA_MIN);
    end
  end

  always_ff @(posedge clk) begin
    out_addr <= in_addr;
    for (int c = 0; c < 3; c++) begin
      sum[c] <= sum_next[c];
    end
  end

  assign out_data = {rbma_pkg::ALPHA_OPAQUE, rbma_pkg::div255(sum[2]),
                     rbma_pkg::div255(sum[1]), rbma_pkg::div255(sum[0])};

endmodule

>>> rtl/core/rect_blit_mirror_alpha_core.sv
// Top level of the rectangle blit core with mirroring and alpha blend.
//
// Requests enter on req/req_valid and are taken when req_stall is low; one
// response per request leaves on rsp/rsp_valid and is taken when rsp_stall
// is low. The core works on one request at a time; a finished response
// waits in the output register, and the next request may be taken
// meanwhile.
// Pixel writes pass through S_PIX and S_DONE on the way to the response,
// and in-range destination reads through S_PIX, S_RDWAIT and S_DONE. A blit
// walks its rectangle one position per cycle, set by the single read and
// write port of each pixel store; out-of-range positions are stepped through unwritten.
// Blends go through a registered multiply step and a scale step behind
// the store reads.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken at once and
// belong in idle periods only.
// Reset loads the default image sizes and empties the pipeline; the pixel
// stores are not cleared and hold undefined data until written.
// A stalled response holds the output register, and a second finished
// response waits inside until it drains.
module rect_blit_mirror_alpha_core #(
  parameter int MAX_DIM = rbma_pkg::MAX_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  rbma_pkg::req_t                     req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output rbma_pkg::rsp_t                     rsp,
  input  logic                               cfg_we,
  input  logic [rbma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbma_pkg::CFG_W-1:0]         cfg_data
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = $clog2(DEPTH);
  localparam int DIM_CAP = (MAX_DIM > 127) ? 127 : MAX_DIM;
  localparam int CW      = rbma_pkg::CFG_W;
  localparam int PW      = rbma_pkg::POS_W;
  localparam int LW      = rbma_pkg::LIN_W;
  localparam int NW      = rbma_pkg::CNT_W;
  localparam logic [CW-1:0] CAP = CW'(DIM_CAP);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PIX    = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_BLIT   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  function automatic logic pos_ok(input logic signed [PW-1:0] v, input logic [CW-1:0] lim);
    return !v[PW-1] && (v[PW-2:0] < {{(PW-1-CW){1'b0}}, lim});
  endfunction

  logic [2:0]     state;
  rbma_pkg::req_t req_r;
  rbma_pkg::rsp_t res;

  logic [CW-1:0] src_w, src_h, dst_w, dst_h;
  logic [CW-1:0] sw, sh, dw, dh;

  logic [CW-1:0] bx, by;
  logic [NW-1:0] cnt;

  logic          pix_ok;
  logic [CW-1:0] pix_w, pix_h;
  logic [LW-1:0] pix_lin;
  logic [AW-1:0] pix_addr;

  logic signed [PW-1:0] rsx, rsy, rdx, rdy, xo, yo, rwo;
  logic signed [PW-1:0] sxx, syy, dxx, dyy;
  logic                 b_ok;

  logic          p1_v, p2_v;
  logic [CW-1:0] p1_sx, p1_sy, p1_dx, p1_dy;
  logic [LW-1:0] bsrc_lin, bdst_lin;
  logic [AW-1:0] p2_addr;

  logic [31:0]   src_q, dst_q;
  logic          src_we, dst_we;
  logic [AW-1:0] dst_waddr, dst_raddr;
  logic [31:0]   dst_wdata;
  logic          pix_dst_we, copy_we;
  logic          blend_v;
  logic [AW-1:0] blend_addr;
  logic [31:0]   blend_data;
  logic          drain_done;
  logic          rsp_free;
  logic          last_col, last_row;

  assign sw = (src_w > CAP) ? CAP : src_w;
  assign sh = (src_h > CAP) ? CAP : src_h;
  assign dw = (dst_w > CAP) ? CAP : dst_w;
  assign dh = (dst_h > CAP) ? CAP : dst_h;

  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Pixel write and read addressing.
  assign pix_w   = (req_r.req_type == rbma_pkg::REQ_WR_SRC) ? sw : dw;
  assign pix_h   = (req_r.req_type == rbma_pkg::REQ_WR_SRC) ? sh : dh;
  assign pix_ok  = ({1'b0, req_r.pixel_x} < pix_w) && ({1'b0, req_r.pixel_y} < pix_h);
  assign pix_lin = LW'(req_r.pixel_y) * LW'(pix_w) + LW'(req_r.pixel_x);
  assign pix_addr = AW'(pix_lin);

  // Blit position generation for the current rectangle position.
  assign rsx = {{(PW-8){req_r.rect_src_x[7]}}, req_r.rect_src_x};
  assign rsy = {{(PW-8){req_r.rect_src_y[7]}}, req_r.rect_src_y};
  assign rdx = {{(PW-8){req_r.rect_dst_x[7]}}, req_r.rect_dst_x};
  assign rdy = {{(PW-8){req_r.rect_dst_y[7]}}, req_r.rect_dst_y};
  assign xo  = {{(PW-CW){1'b0}}, bx};
  assign yo  = {{(PW-CW){1'b0}}, by};
  assign rwo = {{(PW-CW){1'b0}}, req_r.rect_width};

  assign sxx = req_r.mirror_flag ? (rsx + rwo - 10'sd1 - xo) : (rsx + xo);
  assign syy = rsy + yo;
  assign dxx = rdx + xo;
  assign dyy = rdy + yo;
  assign b_ok = (state == S_BLIT) && pos_ok(sxx, sw) && pos_ok(syy, sh)
                && pos_ok(dxx, dw) && pos_ok(dyy, dh);

  assign last_col = (bx == req_r.rect_width - 7'd1);
  assign last_row = (by == req_r.rect_height - 7'd1);

  // Address stage of the blit pipeline.
  assign bsrc_lin = LW'(p1_sy) * LW'(sw) + LW'(p1_sx);
  assign bdst_lin = LW'(p1_dy) * LW'(dw) + LW'(p1_dx);

  assign pix_dst_we = (state == S_PIX) && (req_r.req_type == rbma_pkg::REQ_WR_DST) && pix_ok;
  assign copy_we    = p2_v && !req_r.blend_flag;
  assign src_we     = (state == S_PIX) && (req_r.req_type == rbma_pkg::REQ_WR_SRC) && pix_ok;
  assign dst_we     = pix_dst_we || copy_we || blend_v;
  assign dst_raddr  = (state == S_PIX) ? pix_addr : AW'(bdst_lin);
  assign drain_done = !p1_v && !p2_v && !blend_v;

  always_comb begin
    priority if (pix_dst_we) begin
      dst_waddr = pix_addr;
      dst_wdata = req_r.pixel_rgba;
    end else if (copy_we) begin
      dst_waddr = p2_addr;
      dst_wdata = src_q;
    end else begin
      dst_waddr = blend_addr;
      dst_wdata = blend_data;
    end
  end

  rbma_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (pix_addr),
    .wdata (req_r.pixel_rgba),
    .raddr (AW'(bsrc_lin)),
    .rdata (src_q)
  );

  rbma_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_dst_ram (
    .clk   (clk),
    .we    (dst_we),
    .waddr (dst_waddr),
    .wdata (dst_wdata),
    .raddr (dst_raddr),
    .rdata (dst_q)
  );

  rbma_blend #(.AW(AW)) u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p2_v && req_r.blend_flag),
    .in_addr   (p2_addr),
    .src       (src_q),
    .dst       (dst_q),
    .out_valid (blend_v),
    .out_addr  (blend_addr),
    .out_data  (blend_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      bx        <= '0;
      by        <= '0;
      cnt       <= '0;
      src_w     <= rbma_pkg::SRC_WIDTH_RST;
      src_h     <= rbma_pkg::SRC_HEIGHT_RST;
      dst_w     <= rbma_pkg::DST_WIDTH_RST;
      dst_h     <= rbma_pkg::DST_HEIGHT_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rbma_pkg::CFG_SRC_WIDTH:  src_w <= cfg_data;
          rbma_pkg::CFG_SRC_HEIGHT: src_h <= cfg_data;
          rbma_pkg::CFG_DST_WIDTH:  dst_w <= cfg_data;
          rbma_pkg::CFG_DST_HEIGHT: dst_h <= cfg_data;
        endcase
      end

      p1_v <= b_ok;
      p2_v <= p1_v;
      if (copy_we || blend_v) begin
        cnt <= cnt + NW'(1);
      end

      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            bx  <= '0;
            by  <= '0;
            cnt <= '0;
            if (req.req_type != rbma_pkg::REQ_BLIT) begin
              state <= S_PIX;
            end else if (req.rect_width == '0 || req.rect_height == '0) begin
              state <= S_DRAIN;
            end else begin
              state <= S_BLIT;
            end
          end
        end
        S_PIX: begin
          if (req_r.req_type == rbma_pkg::REQ_RD_DST && pix_ok) begin
            state <= S_RDWAIT;
          end else begin
            state <= S_DONE;
          end
        end
        S_RDWAIT: state <= S_DONE;
        S_BLIT: begin
          if (last_col) begin
            bx <= '0;
            if (last_row) begin
              state <= S_DRAIN;
            end else begin
              by <= by + CW'(1);
            end
          end else begin
            bx <= bx + CW'(1);
          end
        end
        S_DRAIN: begin
          if (drain_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req_r <= req;
    end
    p1_sx   <= sxx[CW-1:0];
    p1_sy   <= syy[CW-1:0];
    p1_dx   <= dxx[CW-1:0];
    p1_dy   <= dyy[CW-1:0];
    p2_addr <= AW'(bdst_lin);
    if (state == S_PIX) begin
      res.read_rgba      <= '0;
      res.pixels_written <= '0;
      res.in_range       <= pix_ok;
    end else if (state == S_RDWAIT) begin
      res.read_rgba <= dst_q;
    end else if (state == S_DRAIN) begin
      res.read_rgba      <= '0;
      res.pixels_written <= cnt;
      res.in_range       <= 1'b0;
    end
    if (state == S_DONE && rsp_free) begin
      rsp <= res;
    end
  end

  a_single_dst_writer: assert property (@(posedge clk) disable iff (rst)
    !(copy_we && blend_v) && !(pix_dst_we && (copy_we || blend_v)))
    else $error("Two sources write the destination store in one cycle.");

  a_rdwait_follows_pix: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDWAIT) |-> ($past(state) == S_PIX))
    else $error("Read data wait entered without a pixel access.");

  a_pipe_only_in_blit: assert property (@(posedge clk) disable iff (rst)
    (p1_v || p2_v || blend_v) |-> (state == S_BLIT || state == S_DRAIN))
    else $error("Blit pipeline busy outside a blit.");

  a_done_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && rsp_valid && rsp_stall) |=> (state == S_DONE))
    else $error("Response left the core while the output register was full.");

endmodule
